@@ rtl/core/glos_pkg.sv @@
`timescale 1ns / 1ps

package glos_pkg;

   // Fixed field widths
   localparam int COORD_W    = 12;
   localparam int TILE_W     = 6;
   localparam int SHIFT_W    = 3;
   localparam int RADIUS_W   = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   // Command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SHIFT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_RADIUS = 1'b1;

   // Register reset values
   localparam logic [SHIFT_W-1:0]  TILE_SHIFT_RST    = 3'd4;
   localparam logic [RADIUS_W-1:0] DETECT_RADIUS_RST = 12'd200;

   typedef struct packed {
      logic               cmd;
      logic [TILE_W-1:0]  tile_x;
      logic [TILE_W-1:0]  tile_y;
      logic               solid_bit;
      logic [COORD_W-1:0] source_x;
      logic [COORD_W-1:0] source_y;
      logic [COORD_W-1:0] target_x;
      logic [COORD_W-1:0] target_y;
   } req_type;

   typedef struct packed {
      logic detected;
      logic in_range;
      logic line_clear;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_CMP,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

@@ rtl/core/grid_line_of_sight_detector.sv @@
`timescale 1ns / 1ps

// Grid line-of-sight detector.
// req_*  : input beats. cmd write sets one occupancy tile (no response);
//          cmd query compares squared pixel distance against detect_radius^2 and,
//          when in range, walks a Bresenham line over tiles, source to target.
// rsp_*  : one beat per query: detected, in_range, line_clear.
// csr_*  : register writes (index 0 tile_shift, 1 detect_radius), always ready.
// Query flow: setup states DIFF, MUL and CMP, then the walk over tiles,
//          then DONE posts the result; out-of-range queries skip the walk.
//          The walk issues one grid read per cycle and checks it the next
//          cycle, so it is paced by the single grid read port.
// One item is in flight at a time: req_ready is high only when idle.
// The response sits in an output register; a stalled receiver holds the next
// query in its final cycle until the register frees up, while the current
// beat stays stable.
// Reset: registers take tile_shift 4, detect_radius 200, and the grid is swept
// to free, one entry a cycle, over all 2**(clog2(GRID_W)+clog2(GRID_H)) entries
// (4096 by default); req_ready stays low until the sweep ends.
// Tiles outside the grid count as solid; writes outside the grid are dropped.
module grid_line_of_sight_detector #(
   parameter int GRID_W     = 64,
   parameter int GRID_H     = 64,
   parameter int COORD_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  glos_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output glos_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [glos_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [glos_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int CW    = glos_pkg::COORD_W;
   localparam int CW1   = CW + 1;
   localparam int RW    = glos_pkg::RADIUS_W;
   localparam int SW    = glos_pkg::SHIFT_W;
   localparam int XB    = $clog2(GRID_W);
   localparam int YB    = $clog2(GRID_H);
   localparam int AW    = XB + YB;
   localparam int MB    = (COORD_BITS < CW) ? COORD_BITS : CW;
   localparam int DW    = 2 * CW + 1;
   localparam int ERR_W = CW + 3;
   localparam int E2W   = ERR_W + 1;

   localparam logic [CW-1:0] COORD_MASK = CW'((32'd1 << MB) - 32'd1);
   localparam logic [CW:0]   GRID_W_C   = CW1'(GRID_W);
   localparam logic [CW:0]   GRID_H_C   = CW1'(GRID_H);
   localparam logic [AW-1:0] ADDR_LAST  = {AW{1'b1}};

   glos_pkg::state_type state_ff, state_in;

   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   logic [SW-1:0]       tile_shift_ff;
   logic [RW-1:0]       radius_ff;

   logic [CW-1:0]       src_x_ff, src_x_in, src_y_ff, src_y_in;
   logic [CW-1:0]       tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [CW-1:0]       pdx_ff, pdx_in, pdy_ff, pdy_in;
   logic [CW-1:0]       cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [CW-1:0]       end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic                xneg_ff, xneg_in, yneg_ff, yneg_in;
   logic [CW-1:0]       tdx_ff, tdx_in, tdy_ff, tdy_in;
   logic [2*CW-1:0]     dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [2*RW-1:0]     rad2_ff, rad2_in;
   logic signed [ERR_W-1:0] err_ff, err_in;

   logic                issued_ff, issued_in;
   logic                pend_vld_ff, pend_vld_in;
   logic                pend_last_ff, pend_last_in;
   logic                pend_oob_ff, pend_oob_in;
   logic                res_range_ff, res_range_in;
   logic                res_clear_ff, res_clear_in;

   logic                rsp_valid_ff, rsp_valid_in;
   glos_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // grid port
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic                wr_bit;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                rd_bit;

   // walk datapath
   logic [CW-1:0]           x0, y0, x1, y1;
   logic [CW-1:0]           req_tx, req_ty;
   logic                    req_in_grid;
   logic                    oob_cur, at_end;
   logic signed [E2W-1:0]   e2, tdx_e, tdy_e;
   logic                    step_x, step_y;
   logic [DW-1:0]           dist2;
   logic                    req_fire;

   glos_grid_ram #(
      .AW (AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_bit  (wr_bit),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_bit  (rd_bit)
   );

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == glos_pkg::ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tile_shift_ff <= glos_pkg::TILE_SHIFT_RST;
         radius_ff     <= glos_pkg::DETECT_RADIUS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            glos_pkg::CSR_TILE_SHIFT: begin
               tile_shift_ff <= csr_data[SW-1:0];
            end
            glos_pkg::CSR_DETECT_RADIUS: begin
               radius_ff <= csr_data[RW-1:0];
            end
         endcase
      end
   end

   // Tile coordinates from pixels
   assign x0 = src_x_ff >> tile_shift_ff;
   assign y0 = src_y_ff >> tile_shift_ff;
   assign x1 = tgt_x_ff >> tile_shift_ff;
   assign y1 = tgt_y_ff >> tile_shift_ff;

   assign req_tx      = CW'(req_data.tile_x);
   assign req_ty      = CW'(req_data.tile_y);
   assign req_in_grid = ({1'b0, req_tx} < GRID_W_C) && ({1'b0, req_ty} < GRID_H_C);

   // Walk step
   assign oob_cur = ({1'b0, cur_x_ff} >= GRID_W_C) || ({1'b0, cur_y_ff} >= GRID_H_C);
   assign at_end  = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   assign e2      = {err_ff, 1'b0};
   assign tdx_e   = E2W'(tdx_ff);
   assign tdy_e   = E2W'(tdy_ff);
   assign step_x  = e2 > -tdy_e;
   assign step_y  = e2 < tdx_e;
   assign dist2   = DW'(dx2_ff) + DW'(dy2_ff);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      src_x_in     = src_x_ff;
      src_y_in     = src_y_ff;
      tgt_x_in     = tgt_x_ff;
      tgt_y_in     = tgt_y_ff;
      pdx_in       = pdx_ff;
      pdy_in       = pdy_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      xneg_in      = xneg_ff;
      yneg_in      = yneg_ff;
      tdx_in       = tdx_ff;
      tdy_in       = tdy_ff;
      dx2_in       = dx2_ff;
      dy2_in       = dy2_ff;
      rad2_in      = rad2_ff;
      err_in       = err_ff;
      issued_in    = issued_ff;
      pend_vld_in  = 1'b0;
      pend_last_in = pend_last_ff;
      pend_oob_in  = pend_oob_ff;
      res_range_in = res_range_ff;
      res_clear_in = res_clear_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = {req_ty[YB-1:0], req_tx[XB-1:0]};
      wr_bit       = req_data.solid_bit;
      rd_en        = 1'b0;
      rd_addr      = {cur_y_ff[YB-1:0], cur_x_ff[XB-1:0]};

      unique case (state_ff)
         glos_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_bit      = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_LAST) begin
               state_in = glos_pkg::ST_IDLE;
            end
         end
         glos_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == glos_pkg::CMD_WRITE) begin
                  wr_en = req_in_grid;
               end else begin
                  src_x_in = req_data.source_x & COORD_MASK;
                  src_y_in = req_data.source_y & COORD_MASK;
                  tgt_x_in = req_data.target_x & COORD_MASK;
                  tgt_y_in = req_data.target_y & COORD_MASK;
                  state_in = glos_pkg::ST_DIFF;
               end
            end
         end
         glos_pkg::ST_DIFF: begin
            pdx_in   = (tgt_x_ff > src_x_ff) ? tgt_x_ff - src_x_ff : src_x_ff - tgt_x_ff;
            pdy_in   = (tgt_y_ff > src_y_ff) ? tgt_y_ff - src_y_ff : src_y_ff - tgt_y_ff;
            cur_x_in = x0;
            cur_y_in = y0;
            end_x_in = x1;
            end_y_in = y1;
            xneg_in  = !(x0 < x1);
            yneg_in  = !(y0 < y1);
            tdx_in   = (x1 > x0) ? x1 - x0 : x0 - x1;
            tdy_in   = (y1 > y0) ? y1 - y0 : y0 - y1;
            state_in = glos_pkg::ST_MUL;
         end
         glos_pkg::ST_MUL: begin
            dx2_in   = pdx_ff * pdx_ff;
            dy2_in   = pdy_ff * pdy_ff;
            rad2_in  = radius_ff * radius_ff;
            state_in = glos_pkg::ST_CMP;
         end
         glos_pkg::ST_CMP: begin
            err_in      = ERR_W'(tdx_e - tdy_e);
            issued_in   = 1'b0;
            res_range_in = (dist2 <= DW'(rad2_ff));
            res_clear_in = 1'b0;
            if (dist2 <= DW'(rad2_ff)) begin
               state_in = glos_pkg::ST_WALK;
            end else begin
               state_in = glos_pkg::ST_DONE;
            end
         end
         glos_pkg::ST_WALK: begin
            // issue a read for the current tile and advance speculatively;
            // the tile read last cycle is judged now
            if (!issued_ff) begin
               rd_en        = 1'b1;
               pend_vld_in  = 1'b1;
               pend_last_in = at_end;
               pend_oob_in  = oob_cur;
               issued_in    = at_end;
               if (!at_end) begin
                  err_in = ERR_W'(e2 >>> 1)
                           + (step_x ? -ERR_W'(tdy_ff) : '0)
                           + (step_y ? ERR_W'(tdx_ff) : '0);
                  if (step_x) begin
                     cur_x_in = xneg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
                  end
                  if (step_y) begin
                     cur_y_in = yneg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
                  end
               end
            end
            if (pend_vld_ff) begin
               if (rd_bit || pend_oob_ff) begin
                  res_clear_in = 1'b0;
                  pend_vld_in  = 1'b0;
                  state_in     = glos_pkg::ST_DONE;
               end else if (pend_last_ff) begin
                  res_clear_in = 1'b1;
                  pend_vld_in  = 1'b0;
                  state_in     = glos_pkg::ST_DONE;
               end
            end
         end
         glos_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.detected   = res_range_ff & res_clear_ff;
               rsp_data_in.in_range   = res_range_ff;
               rsp_data_in.line_clear = res_clear_ff;
               state_in               = glos_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= glos_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         issued_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_vld_ff  <= pend_vld_in;
         issued_ff    <= issued_in;
      end
   end

   always_ff @(posedge clock) begin
      src_x_ff     <= src_x_in;
      src_y_ff     <= src_y_in;
      tgt_x_ff     <= tgt_x_in;
      tgt_y_ff     <= tgt_y_in;
      pdx_ff       <= pdx_in;
      pdy_ff       <= pdy_in;
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      end_x_ff     <= end_x_in;
      end_y_ff     <= end_y_in;
      xneg_ff      <= xneg_in;
      yneg_ff      <= yneg_in;
      tdx_ff       <= tdx_in;
      tdy_ff       <= tdy_in;
      dx2_ff       <= dx2_in;
      dy2_ff       <= dy2_in;
      rad2_ff      <= rad2_in;
      err_ff       <= err_in;
      pend_last_ff <= pend_last_in;
      pend_oob_ff  <= pend_oob_in;
      res_range_ff <= res_range_in;
      res_clear_ff <= res_clear_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Pending grid reads exist only during a walk
   a_pend_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (state_ff == glos_pkg::ST_WALK))
      else $error("pending tile read outside walk");

   // Once the last tile is issued the walker sits on the target tile
   a_issued_at_end: assert property (@(posedge clock) disable iff (reset)
      (issued_ff && state_ff == glos_pkg::ST_WALK) |-> at_end)
      else $error("walk issued past the target tile");

   // Grid is never written while a walk reads it
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == glos_pkg::ST_WALK) |-> !wr_en)
      else $error("grid write during walk");

   // A response beat only appears out of the result state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == glos_pkg::ST_DONE))
      else $error("response posted outside result state");

   // A query beat starts the setup sequence
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.cmd == glos_pkg::CMD_QUERY) |=> (state_ff == glos_pkg::ST_DIFF))
      else $error("query not started");

endmodule

@@ rtl/core/glos_grid_ram.sv @@
`timescale 1ns / 1ps

// 1-bit occupancy store, one write port, one read port, registered read.
module glos_grid_ram #(
   parameter int AW = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_bit,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_bit
);

   logic mem [2**AW];
   logic rd_bit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_bit_ff <= mem[rd_addr];
      end
   end

   assign rd_bit = rd_bit_ff;

endmodule

@@ bench/glos_checker.sv @@
`timescale 1ns / 1ps

module glos_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  glos_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  glos_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [glos_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [glos_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              mismatch_count,
   output int                              pending_count,
   output int                              checked_count
);

   localparam int GRID_SIDE = 64;

   bit                            occupancy [GRID_SIDE*GRID_SIDE];
   logic [glos_pkg::SHIFT_W-1:0]  shift_cfg;
   logic [glos_pkg::RADIUS_W-1:0] radius_cfg;
   glos_pkg::rsp_type             sight_expect_q[$];

   // Range test on pixels, then a Bresenham walk over tiles; off-grid tiles block.
   function automatic glos_pkg::rsp_type predict_sight(input glos_pkg::req_type q);
      longint            ddx, ddy, rad;
      int                x, y, x1, y1, dx, dy, step_x, step_y, err, e2;
      bit                walking;
      glos_pkg::rsp_type r;
      ddx = longint'(q.target_x) - longint'(q.source_x);
      ddy = longint'(q.target_y) - longint'(q.source_y);
      if (ddx < 0) ddx = -ddx;
      if (ddy < 0) ddy = -ddy;
      rad = longint'(radius_cfg);
      r.in_range   = (ddx * ddx + ddy * ddy <= rad * rad);
      r.line_clear = 1'b0;
      if (r.in_range) begin
         x  = int'(q.source_x >> shift_cfg);
         y  = int'(q.source_y >> shift_cfg);
         x1 = int'(q.target_x >> shift_cfg);
         y1 = int'(q.target_y >> shift_cfg);
         dx = (x1 > x) ? x1 - x : x - x1;
         dy = (y1 > y) ? y1 - y : y - y1;
         step_x  = (x < x1) ? 1 : -1;
         step_y  = (y < y1) ? 1 : -1;
         err     = dx - dy;
         walking = 1'b1;
         while (walking) begin
            if (x < 0 || y < 0 || x >= GRID_SIDE || y >= GRID_SIDE ||
                occupancy[y * GRID_SIDE + x]) begin
               walking = 1'b0;
            end else if (x == x1 && y == y1) begin
               r.line_clear = 1'b1;
               walking      = 1'b0;
            end else begin
               e2 = 2 * err;
               if (e2 > -dy) begin
                  err -= dy;
                  x   += step_x;
               end
               if (e2 < dx) begin
                  err += dx;
                  y   += step_y;
               end
            end
         end
      end
      r.detected = r.in_range & r.line_clear;
      return r;
   endfunction

   always @(posedge clock) begin
      glos_pkg::rsp_type want;
      glos_pkg::rsp_type fresh;
      if (reset) begin
         foreach (occupancy[i]) occupancy[i] = 1'b0;
         shift_cfg  = glos_pkg::TILE_SHIFT_RST;
         radius_cfg = glos_pkg::DETECT_RADIUS_RST;
         sight_expect_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == glos_pkg::CSR_TILE_SHIFT)
               shift_cfg = csr_data[glos_pkg::SHIFT_W-1:0];
            else
               radius_cfg = csr_data[glos_pkg::RADIUS_W-1:0];
         end
         if (req_valid && req_ready) begin
            // 64x64 grid: every 6-bit tile address lands inside it
            if (req_data.cmd == glos_pkg::CMD_WRITE) begin
               occupancy[{req_data.tile_y, req_data.tile_x}] = req_data.solid_bit;
            end else begin
               fresh          = predict_sight(req_data);
               sight_expect_q = {sight_expect_q, fresh};
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sight_expect_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result beat det=%b rng=%b clr=%b", $realtime,
                           rsp_data.detected, rsp_data.in_range, rsp_data.line_clear);
            end else begin
               want = sight_expect_q.pop_front();
               checked_count++;
               if (rsp_data.detected !== want.detected || rsp_data.in_range !== want.in_range ||
                   rsp_data.line_clear !== want.line_clear) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result %0d exp det=%b rng=%b clr=%b got det=%b rng=%b clr=%b",
                              $realtime, checked_count, want.detected, want.in_range,
                              want.line_clear, rsp_data.detected, rsp_data.in_range,
                              rsp_data.line_clear);
               end
            end
         end
      end
      pending_count = sight_expect_q.size();
   end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int N_PHASES         = 8;
   localparam int RANDOM_PER_PHASE = 240;
   // Grid sweep after reset, then per item: a walk never passes more than one
   // tile beyond the 64x64 grid, plus sender gaps and
   // receiver stalls, with wide margin.
   localparam int          CLEAR_CYCLES      = 4096;
   localparam int          WORST_ITEM_CYCLES = 600;
   localparam int unsigned CYCLE_LIMIT       = CLEAR_CYCLES + 2200 * WORST_ITEM_CYCLES;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   glos_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   glos_pkg::rsp_type               rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [glos_pkg::CSR_IDX_W-1:0]  csr_index = glos_pkg::CSR_TILE_SHIFT;
   logic [glos_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   int mismatch_count, pending_count, checked_count;

   int          send_idle_pct = 0;
   int          rsp_idle_pct  = 0;
   int          beats_sent    = 0;
   int          writes_sent   = 0;
   int          settings_used = 0;
   int          cur_shift     = 4;
   int          cur_radius    = 200;
   int unsigned cycle_count   = 0;

   // Register plan per phase: reset values first, then the extremes and a few
   // in between. Shift 7 is beyond the nominal range but the field allows it.
   int shift_plan  [N_PHASES] = '{4, 0, 6, 7, 2, 5, 1, 3};
   int radius_plan [N_PHASES] = '{200, 4095, 0, 4095, 90, 2000, 4095, 700};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   grid_line_of_sight_detector i_dut (.*);

   glos_checker i_checker (.*);

   // Receiver back-pressure, redrawn every cycle on the falling edge
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit, %0d results still owed", pending_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one beat and hold it until accepted. Called and returns on a falling
   // edge; valid is only touched once per step.
   task automatic send_beat(input glos_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
      if (item.cmd == glos_pkg::CMD_WRITE) writes_sent++;
   endtask

   // Sender holds off until every outstanding query has been answered.
   // Always advances at least one step so valid is not dropped and raised together.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   // Unused fields of each beat carry random junk so all bits toggle.
   task automatic put_tile(input int x, input int y, input bit solid);
      logic [63:0]       junk;
      glos_pkg::req_type item;
      junk           = {$urandom, $urandom};
      item           = junk[$bits(glos_pkg::req_type)-1:0];
      item.cmd       = glos_pkg::CMD_WRITE;
      item.tile_x    = x[glos_pkg::TILE_W-1:0];
      item.tile_y    = y[glos_pkg::TILE_W-1:0];
      item.solid_bit = solid;
      send_beat(item);
   endtask

   task automatic ask_sight(input int sx, input int sy, input int tx, input int ty);
      logic [63:0]       junk;
      glos_pkg::req_type item;
      junk          = {$urandom, $urandom};
      item          = junk[$bits(glos_pkg::req_type)-1:0];
      item.cmd      = glos_pkg::CMD_QUERY;
      item.source_x = sx[glos_pkg::COORD_W-1:0];
      item.source_y = sy[glos_pkg::COORD_W-1:0];
      item.target_x = tx[glos_pkg::COORD_W-1:0];
      item.target_y = ty[glos_pkg::COORD_W-1:0];
      send_beat(item);
   endtask

   // Both registers back to back on the CSR channel; valid stays high between
   // the two beats. Only done with the block idle.
   task automatic set_registers(input int shift_val, input int radius_val);
      drain_results();
      // a tile write may still be settling with nothing owed
      repeat (8) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= glos_pkg::CSR_TILE_SHIFT;
      csr_data  <= shift_val[glos_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= glos_pkg::CSR_DETECT_RADIUS;
      csr_data  <= radius_val[glos_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid  <= 1'b0;
      cur_shift  = shift_val;
      cur_radius = radius_val;
      settings_used++;
   endtask

   initial begin
      int sx, sy, tx, ty, span, reach;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      // grid is swept clear after reset; block signals readiness when done
      while (!req_ready) @(negedge clock);

      for (int p = 0; p < N_PHASES; p++) begin
         // stall mix: light sender gaps + heavy receiver stalls, then swapped, then none
         if (p < 3) begin
            send_idle_pct = 10;
            rsp_idle_pct  = 47;
         end else if (p < 6) begin
            send_idle_pct = 47;
            rsp_idle_pct  = 10;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         set_registers(shift_plan[p], radius_plan[p]);

         if (p == 0) begin
            // directed: shift 4 (16 px tiles), radius 200
            ask_sight(0, 0, 0, 0);                 // empty grid, same point
            ask_sight(4095, 4095, 4095, 4095);     // max coords, tile off grid
            put_tile(0, 0, 1);
            ask_sight(3, 3, 3, 3);                 // solid endpoint
            put_tile(63, 63, 1);
            ask_sight(1015, 1015, 1000, 1000);     // source on solid corner tile
            ask_sight(8, 40, 208, 40);             // exactly at radius, open row
            ask_sight(8, 40, 209, 40);             // one pixel past radius
            put_tile(5, 2, 1);
            ask_sight(8, 40, 208, 40);             // obstacle mid-line
            ask_sight(208, 40, 8, 40);             // same line walked backward
            put_tile(5, 2, 0);
            ask_sight(208, 40, 8, 40);             // obstacle cleared again
            ask_sight(1000, 1000, 859, 859);       // diagonal, both steps negative
            ask_sight(500, 300, 540, 480);         // steep line
            put_tile(32, 24, 1);
            ask_sight(500, 300, 540, 480);
            ask_sight(540, 480, 500, 300);
            ask_sight(4000, 4000, 4095, 4095);     // source off grid
            ask_sight(1020, 500, 1190, 500);       // walk runs off the grid edge
            put_tile(63, 0, 1);
            ask_sight(1023, 0, 1023, 0);
            put_tile(0, 63, 0);
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2) drain_results();
            if ($urandom_range(99) < 35) begin
               put_tile($urandom_range(63), $urandom_range(63), $urandom_range(99) < 35);
            end else if ($urandom_range(9) == 0) begin
               // anywhere in pixel space
               ask_sight($urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095));
            end else begin
               // source over the grid, target near the radius so range goes both ways
               span = (64 << cur_shift) - 1;
               if (span > 4095) span = 4095;
               reach = cur_radius + cur_radius / 4 + 1;
               sx = $urandom_range(span);
               sy = $urandom_range(span);
               tx = sx + $urandom_range(2 * reach) - reach;
               ty = sy + $urandom_range(2 * reach) - reach;
               if (tx < 0) tx = 0;
               if (ty < 0) ty = 0;
               if (tx > 4095) tx = 4095;
               if (ty > 4095) ty = 4095;
               ask_sight(sx, sy, tx, ty);
            end
         end
      end

      drain_results();
      repeat (100) @(negedge clock);

      $display("Sent %0d beats (%0d tile writes), checked %0d sight results, %0d mismatches",
               beats_sent, writes_sent, checked_count, mismatch_count);
      $display("over %0d register settings: tile shift 0..7, radius 0..4095, three stall mixes",
               settings_used);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/glos_pkg.sv
rtl/core/glos_grid_ram.sv
rtl/core/grid_line_of_sight_detector.sv
bench/glos_checker.sv
bench/tb.sv
